@@ rtl/core/kts_pkg.sv @@
// Shared types, constants and helper functions for the Koch turn sequence generator.
// No dependencies; used by kts_level_scan and koch_turn_sequence_generator.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

   // Fixed field widths.
   localparam int SEG_W       = 22;
   localparam int TURN_W      = 3;
   localparam int HEAD_W      = 3;
   localparam int DEPTH_W     = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   // Deepest curve whose indexes still fit in SEG_W bits.
   localparam int DEPTH_CAP = 10;

   // Six headings of 60 degrees each.
   localparam logic [HEAD_W-1:0] HEADINGS = 3'd6;

   // Turn codes in signed units of 60 degrees.
   localparam logic signed [TURN_W-1:0] TURN_NONE     = 3'sd0;
   localparam logic signed [TURN_W-1:0] TURN_PLUS120  = 3'sd2;
   localparam logic signed [TURN_W-1:0] TURN_MINUS60  = -3'sd1;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEPTH_LEVELS  = 2'd0,
      CSR_MIRROR_MODE   = 2'd1,
      CSR_START_HEADING = 2'd2
   } csr_index_type;

   // Mod-3 level counter states.
   typedef logic [1:0] level_count_type;

   // Brings a 3-bit heading into 0..5.
   function automatic logic [HEAD_W-1:0] heading_mod6(input logic [HEAD_W-1:0] h);
      return (h >= HEADINGS) ? h - HEADINGS : h;
   endfunction

   // Adds a turn of -2..2 to a heading of 0..5, wrapping around the circle.
   function automatic logic [HEAD_W-1:0] heading_turn(
      input logic        [HEAD_W-1:0] h,
      input logic signed [TURN_W-1:0] t
   );
      logic signed [4:0] s;
      s = $signed({2'b00, h}) + $signed({{2{t[TURN_W-1]}}, t});
      if (s < 0) begin
         s = s + 5'sd6;
      end else if (s >= 5'sd6) begin
         s = s - 5'sd6;
      end
      return s[HEAD_W-1:0];
   endfunction

   // Advances a mod-3 counter.
   function automatic level_count_type level_next(input level_count_type c);
      return (c >= 2'd2) ? 2'd0 : c + 2'd1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/kts_level_scan.sv @@
// Trailing base-4 zero digit counter for a segment index, capped at MAX_LEVELS-1.
// Depends on kts_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

module kts_level_scan #(
   parameter  int MAX_LEVELS = 10,
   localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
   input  wire logic [kts_pkg::SEG_W-1:0] seg_index,
   output logic      [LVL_W-1:0]          level
);

   localparam int DIG_W = (2 * MAX_LEVELS > kts_pkg::SEG_W) ? 2 * MAX_LEVELS : kts_pkg::SEG_W;

   logic [DIG_W-1:0] index_wide;
   assign index_wide = DIG_W'(seg_index);

   // Priority encode: the lowest nonzero digit gives the level.
   always_comb begin
      logic found;
      found = 1'b0;
      level = LVL_W'(MAX_LEVELS - 1);
      for (int i = 0; i < MAX_LEVELS - 1; i++) begin
         if (!found && index_wide[2*i +: 2] != 2'b00) begin
            level = LVL_W'(i);
            found = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/koch_turn_sequence_generator.sv @@
// Top level of the Koch snowflake turn sequence generator.
// Depends on kts_pkg and kts_level_scan.
//
//   Channel  Direction  Payload
//   req_     in         tdata[0] restart (1 starts a new curve), tdata[7:1] zero
//   rsp_     out        tdata: segment_index[21:0], turn_step[24:22], heading[27:25];
//                       tlast: last_segment
//   csr_     in         write only: depth_levels (0), mirror_mode (1), start_heading (2)
//
// Every request word yields exactly one response word, one segment per clock.
// The request, the segment counter, the level counters and the heading feed
// combinational logic whose result lands in the response register while the
// state updates, so the next word can follow in the next cycle.
// A request is taken whenever the response register is empty or being drained.
// When the response side stalls, requests stall with it and all state holds.
// Reset (synchronous) sets depth 1, no mirror, start heading 0 and segment 0.
`timescale 1ns / 1ps
`default_nettype none

module koch_turn_sequence_generator #(
   parameter int MAX_LEVELS = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kts_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [0] restart, rest zero
   // Response stream.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [kts_pkg::RSP_TDATA_W-1:0]       rsp_tdata,   // [21:0] segment_index,
                                                              // [24:22] turn_step,
                                                              // [27:25] heading, rest zero
   output logic                                  rsp_tlast,   // last_segment
   // Configuration write port.
   input  wire logic                             csr_we,
   input  wire logic [kts_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [kts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SEG_W     = kts_pkg::SEG_W;
   localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int DEPTH_LIM = (MAX_LEVELS < kts_pkg::DEPTH_CAP) ? MAX_LEVELS
                                                                : kts_pkg::DEPTH_CAP;
   localparam int PAD_W     = kts_pkg::RSP_TDATA_W - SEG_W - kts_pkg::TURN_W - kts_pkg::HEAD_W;

   // Configuration registers.
   logic [kts_pkg::DEPTH_W-1:0] depth_ff;
   logic                        mirror_ff;
   logic [kts_pkg::HEAD_W-1:0]  start_ff;

   // Curve state.
   logic [SEG_W-1:0]              seg_cnt_ff, seg_cnt_in;
   kts_pkg::level_count_type      lvl_cnt_ff [MAX_LEVELS];
   logic [kts_pkg::HEAD_W-1:0]    head_ff, head_in;

   // Response register.
   logic                          rsp_valid_ff;
   logic [SEG_W-1:0]              rsp_index_ff, rsp_index_in;
   logic signed [kts_pkg::TURN_W-1:0] rsp_turn_ff, rsp_turn_in;
   logic [kts_pkg::HEAD_W-1:0]    rsp_head_ff;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          take;
   logic [kts_pkg::DEPTH_W-1:0]   depth_eff;
   logic [SEG_W-1:0]              side_len, side_mask, total_len;
   logic [SEG_W-1:0]              seg_idx;
   logic                          is_first, is_corner;
   logic [LVL_W-1:0]              level;
   kts_pkg::level_count_type      level_cnt;
   logic signed [kts_pkg::TURN_W-1:0] turn_raw;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= kts_pkg::DEPTH_W'(1);
         mirror_ff <= 1'b0;
         start_ff  <= '0;
      end else if (csr_we) begin
         unique case (kts_pkg::csr_index_type'(csr_addr))
            kts_pkg::CSR_DEPTH_LEVELS:  depth_ff  <= csr_wdata[kts_pkg::DEPTH_W-1:0];
            kts_pkg::CSR_MIRROR_MODE:   mirror_ff <= csr_wdata[0];
            kts_pkg::CSR_START_HEADING: start_ff  <= csr_wdata[kts_pkg::HEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // The depth is clipped so that every index of the curve fits the index field.
   assign depth_eff = (depth_ff > kts_pkg::DEPTH_W'(DEPTH_LIM)) ? kts_pkg::DEPTH_W'(DEPTH_LIM)
                                                              : depth_ff;
   assign side_len  = SEG_W'(1) << {depth_eff, 1'b0};
   assign side_mask = side_len - SEG_W'(1);
   assign total_len = (side_len << 1) + side_len;

   // A restart, or a counter past the end of the curve (wrap or depth lowered),
   // emits segment zero of a new curve.
   assign seg_idx   = (req_tdata[0] || seg_cnt_ff >= total_len) ? '0 : seg_cnt_ff;
   assign is_first  = (seg_idx == '0);
   assign is_corner = ((seg_idx & side_mask) == '0);

   kts_level_scan #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_level_scan (
      .seg_index (seg_idx),
      .level     (level)
   );

   assign level_cnt = lvl_cnt_ff[level];

   always_comb begin
      if (is_corner) begin
         turn_raw = kts_pkg::TURN_PLUS120;
      end else if (level_cnt == 2'd1) begin
         turn_raw = kts_pkg::TURN_PLUS120;
      end else begin
         turn_raw = kts_pkg::TURN_MINUS60;
      end

      if (is_first) begin
         rsp_turn_in = kts_pkg::TURN_NONE;
         head_in     = kts_pkg::heading_mod6(start_ff);
      end else begin
         rsp_turn_in = mirror_ff ? -turn_raw : turn_raw;
         head_in     = kts_pkg::heading_turn(head_ff, rsp_turn_in);
      end

      rsp_index_in = seg_idx;
      rsp_last_in  = (seg_idx == total_len - SEG_W'(1));
      seg_cnt_in   = seg_idx + SEG_W'(1);
   end

   // Curve state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff <= '0;
         head_ff    <= '0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            lvl_cnt_ff[i] <= '0;
         end
      end else if (take) begin
         seg_cnt_ff <= seg_cnt_in;
         head_ff    <= head_in;
         if (is_first || is_corner) begin
            // Start of the curve or a side corner: all levels begin afresh.
            for (int i = 0; i < MAX_LEVELS; i++) begin
               lvl_cnt_ff[i] <= '0;
            end
         end else begin
            lvl_cnt_ff[level] <= kts_pkg::level_next(level_cnt);
         end
      end
   end

   // Response register: valid is control, the payload loads on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_index_ff <= rsp_index_in;
         rsp_turn_ff  <= rsp_turn_in;
         rsp_head_ff  <= head_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_head_ff, rsp_turn_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A restart always produces segment zero with no turn.
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (take && req_tdata[0]) |=> (rsp_valid_ff && rsp_index_ff == '0 &&
                                  rsp_turn_ff == kts_pkg::TURN_NONE))
      else $error("restart did not yield segment zero");

   // The heading stays on the six-direction circle.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_head_ff < kts_pkg::HEADINGS))
      else $error("heading out of range");

   // The last segment is never segment zero, so it always carries a turn.
   a_last_turns: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_turn_ff != kts_pkg::TURN_NONE))
      else $error("last segment without a turn");

   // While the response is stalled, the curve does not advance.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(seg_cnt_ff) && $stable(head_ff)))
      else $error("curve state moved during a stall");

endmodule

`default_nettype wire
